@@ hdl/sst_pkg.sv @@
// ----------------------------------------------------------------------------
// sst_pkg: shared types and constants for the sorted set table
// Request and result beats, request codes, cell commands and sequencer states.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] value;
  } sst_req_t;

  typedef struct packed {
    logic       was_present;
    logic       changed;
    logic       full_reject;
    logic [4:0] position;
    logic [4:0] element_count;
  } sst_res_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } sst_state_t;

endpackage

@@ hdl/sst_cell.sv @@
// ----------------------------------------------------------------------------
// sst_cell: one entry of the sorted table
// Compares its entry with the key, then keeps it or takes a neighbour's value
// when the table shifts for an insert or a delete.
// ----------------------------------------------------------------------------
module sst_cell (
  input  logic               clk,
  input  logic signed [31:0] key,
  input  sst_pkg::cell_cmd_t cmd,
  input  logic               valid,
  input  logic               left_lt,
  input  logic signed [31:0] left_entry,
  input  logic signed [31:0] right_entry,
  output logic signed [31:0] entry,
  output logic               lt,
  output logic               eq
);
  import sst_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      lt <= valid && (entry < key);
      eq <= valid && (entry == key);
    end else if (cmd.ins && !lt) begin
      entry <= left_lt ? key : left_entry;
    end else if (cmd.del && !lt) begin
      entry <= right_entry;
    end
  end

endmodule

@@ hdl/sorted_set_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_set_table_core: bounded sorted set of signed 32-bit values
// Lookup, insert and delete over a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request beat (req_type, value) is taken on a rising edge with start high
//   and busy low. busy stays high while the cells compare and then shift. The
//   result beat is registered on res at the end of the shift and shows for
//   exactly one cycle with done high; the receiver cannot stall it.
//   A new request is taken only after the previous one has passed the request
//   register, the compare cycle and the shift cycle of the cell row, with the
//   position encode over the cell flags in the shift cycle.
//   busy is low during the done cycle, so the next request may be offered then.
//   Reset empties the set (count to zero); stored entries are not cleared and
//   only those below the count are ever compared.
//   Insert of a present value, or into a full table, leaves the set alone;
//   the full case raises full_reject. Delete of an absent value does nothing.
//   Request code 3 acts as a lookup.
// ----------------------------------------------------------------------------
module sorted_set_table_core #(
  parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  sst_pkg::sst_req_t req,
  output logic              done,
  output sst_pkg::sst_res_t res
);
  import sst_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  sst_state_t state, state_next;
  sst_req_t   req_q;
  logic [CW-1:0] count;
  cell_cmd_t  cmd;

  logic signed [31:0] entry [CAPACITY];
  logic [CAPACITY-1:0] lt_vec;
  logic [CAPACITY-1:0] eq_vec;
  logic [CAPACITY:0]   bnd;
  logic [CW-1:0]       pos;
  logic present, is_ins, is_del, ins_ok, del_ok, full;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic signed [31:0] l_entry, r_entry;
      logic               l_lt;
      if (g == 0) begin : g_first
        assign l_entry = req_q.value;
        assign l_lt    = 1'b1;
      end else begin : g_mid
        assign l_entry = entry[g-1];
        assign l_lt    = lt_vec[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign r_entry = entry[g];
      end else begin : g_inner
        assign r_entry = entry[g+1];
      end
      sst_cell u_cell (
        .clk        (clk),
        .key        (req_q.value),
        .cmd        (cmd),
        .valid      (count > CW'(g)),
        .left_lt    (l_lt),
        .left_entry (l_entry),
        .right_entry(r_entry),
        .entry      (entry[g]),
        .lt         (lt_vec[g]),
        .eq         (eq_vec[g])
      );
    end
  endgenerate

  // boundary between entries below the key and the rest, one-hot
  always_comb begin
    bnd[0] = !lt_vec[0];
    for (int i = 1; i < CAPACITY; i++) begin
      bnd[i] = lt_vec[i-1] && !lt_vec[i];
    end
    bnd[CAPACITY] = lt_vec[CAPACITY-1];
    pos = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (bnd[i]) pos = pos | CW'(i);
    end
  end

  assign present = |eq_vec;
  assign is_ins  = (req_q.req_type == REQ_INSERT);
  assign is_del  = (req_q.req_type == REQ_DELETE);
  assign full    = is_ins && !present && (count >= CW'(CAPACITY));
  assign ins_ok  = is_ins && !present && (count < CW'(CAPACITY));
  assign del_ok  = is_del && present;

  always_comb begin
    unique case (state)
      ST_IDLE:  state_next = start ? ST_CMP : ST_IDLE;
      ST_CMP:   state_next = ST_APPLY;
      ST_APPLY: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy    = (state != ST_IDLE);
    cmd.cmp = (state == ST_CMP);
    cmd.ins = (state == ST_APPLY) && ins_ok;
    cmd.del = (state == ST_APPLY) && del_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_APPLY);
      if (state == ST_APPLY) begin
        if (ins_ok) count <= count + CW'(1);
        else if (del_ok) count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) req_q <= req;
    if (state == ST_APPLY) begin
      res.was_present   <= present;
      res.changed       <= ins_ok || del_ok;
      res.full_reject   <= full;
      res.position      <= 5'(pos);
      res.element_count <= 5'(ins_ok ? count + CW'(1) : del_ok ? count - CW'(1) : count);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY)) else $error("set count beyond capacity");

  a_done_after_apply: assert property (@(posedge clk) disable iff (rst)
    state == ST_APPLY |=> done) else $error("result beat missing after shift");

  a_done_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_APPLY)) else $error("stray result beat");

  a_changed_count: assert property (@(posedge clk) disable iff (rst)
    done && res.changed |-> count != $past(count)) else $error("change without count step");

  a_full_flags: assert property (@(posedge clk) disable iff (rst)
    done && res.full_reject |-> !res.changed && !res.was_present
      && count == CW'(CAPACITY)) else $error("inconsistent full rejection");

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb: self-checking bench for sorted_set_table_core
// Drives lookup, insert and delete beats from a pending queue and predicts each
// result from a private copy of the sorted table. Results are checked field by
// field in order. The sender idles at varying rates and sometimes waits for
// the table to go quiet before sending again.
// ----------------------------------------------------------------------------
module tb;
  import sst_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [1:0] REQ_SPARE = 2'd3;

  typedef struct {
    sst_req_t    r;
    int unsigned idle_pct;
    bit          drain;
  } pend_item_t;

  logic     clk = 1'b0;
  logic     rst;
  logic     start;
  logic     busy;
  sst_req_t req;
  logic     done;
  sst_res_t res;

  pend_item_t pend_q[$];
  sst_res_t   exp_q[$];
  int         errors = 0;
  int         n_accepted = 0;
  int         n_items = 0;
  int unsigned cur_idle = 0;
  bit         drain_next = 1'b0;

  logic signed [31:0] set_vals [CAP];
  int                 set_cnt = 0;

  sorted_set_table_core #(.CAPACITY(CAP)) uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .res   (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sst_res_t predict_set_op(sst_req_t r);
    sst_res_t o;
    int       pos;
    int       i;
    logic     hit;
    o = '0;
    pos = 0;
    while (pos < set_cnt && $signed(set_vals[pos]) < $signed(r.value)) pos++;
    hit = (pos < set_cnt) && (set_vals[pos] == r.value);
    if (r.req_type == REQ_INSERT && !hit) begin
      if (set_cnt >= CAP) begin
        o.full_reject = 1'b1;
      end else begin
        for (i = set_cnt; i > pos; i--) set_vals[i] = set_vals[i-1];
        set_vals[pos] = r.value;
        set_cnt++;
        o.changed = 1'b1;
      end
    end else if (r.req_type == REQ_DELETE && hit) begin
      for (i = pos; i + 1 < set_cnt; i++) set_vals[i] = set_vals[i+1];
      set_cnt--;
      o.changed = 1'b1;
    end
    o.was_present   = hit;
    o.position      = pos[4:0];
    o.element_count = set_cnt[4:0];
    return o;
  endfunction

  task automatic add_item(logic [1:0] kind, logic signed [31:0] v);
    pend_item_t p;
    p.r.req_type = kind;
    p.r.value    = v;
    p.idle_pct   = cur_idle;
    p.drain      = drain_next;
    drain_next   = 1'b0;
    pend_q.push_back(p);
    n_items++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // driver
  always @(posedge clk) begin : drive
    logic       go;
    sst_req_t   nxt;
    pend_item_t head;
    if (rst) begin
      start <= 1'b0;
      req   <= '0;
    end else begin
      go  = start;
      nxt = req;
      if (start && !busy) begin
        exp_q.push_back(predict_set_op(req));
        n_accepted++;
        go = 1'b0;
      end
      if (!go && pend_q.size() > 0) begin
        if (pend_q[0].drain && exp_q.size() != 0) begin
          go = 1'b0;
        end else if ($urandom_range(0, 99) >= pend_q[0].idle_pct) begin
          head = pend_q.pop_front();
          nxt  = head.r;
          go   = 1'b1;
        end else begin
          pend_q[0].drain = 1'b0;
        end
      end
      start <= go;
      req   <= nxt;
    end
  end

  // monitor
  always @(posedge clk) begin : watch
    sst_res_t want;
    if (!rst && done) begin
      if (exp_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        want = exp_q.pop_front();
        check_field("was_present", want.was_present, res.was_present);
        check_field("changed", want.changed, res.changed);
        check_field("full_reject", want.full_reject, res.full_reject);
        check_field("position", want.position, res.position);
        check_field("element_count", want.element_count, res.element_count);
      end
    end
  end

  initial begin
    #400000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin : stim
    logic signed [31:0] pool [20];
    logic signed [31:0] base;
    logic signed [31:0] v;
    logic [1:0]         kind;
    int                 k;
    int                 n;
    int                 ins_w;
    int                 roll;

    rst = 1'b1;

    // directed: empty table, extremes, duplicates, spare code, full table
    cur_idle = 34;
    add_item(REQ_LOOKUP, 32'sd5);
    add_item(REQ_DELETE, 32'sd5);
    add_item(REQ_INSERT, 32'sh8000_0000);
    add_item(REQ_INSERT, 32'sh7fff_ffff);
    add_item(REQ_INSERT, 32'sd0);
    add_item(REQ_INSERT, -32'sd1);
    add_item(REQ_INSERT, 32'sd1);
    add_item(REQ_INSERT, 32'sd0);
    add_item(REQ_LOOKUP, 32'sd0);
    add_item(REQ_LOOKUP, 32'sd5);
    add_item(REQ_SPARE, 32'sd0);
    add_item(REQ_SPARE, 32'sd7);
    add_item(REQ_DELETE, 32'sd5);
    add_item(REQ_DELETE, 32'sd0);
    add_item(REQ_DELETE, 32'sh8000_0000);
    for (k = 0; k < 13; k++) add_item(REQ_INSERT, 32'sd100 + 32'(k * 3));
    add_item(REQ_INSERT, 32'sd101);
    add_item(REQ_INSERT, 32'sd103);
    add_item(REQ_INSERT, -32'sd1);
    add_item(REQ_LOOKUP, 32'sh7fff_ffff);
    add_item(REQ_DELETE, 32'sh7fff_ffff);

    // random: small value pool so hits and a full table are common
    for (n = 0; n < 1400; n++) begin
      if (n < 470) cur_idle = 34;
      else if (n < 940) cur_idle = 56;
      else cur_idle = 0;
      if (n % 200 == 0 || n == 470 || n == 940) drain_next = 1'b1;
      if (n % 200 == 0) begin
        base    = $urandom();
        pool[0] = 32'sh8000_0000;
        pool[1] = 32'sh7fff_ffff;
        pool[2] = 32'sd0;
        pool[3] = -32'sd1;
        for (k = 4; k < 20; k++) pool[k] = (k < 12) ? base + k : $urandom();
      end
      if (n % 100 == 0) ins_w = $urandom_range(20, 70);
      roll = $urandom_range(0, 99);
      if (roll < ins_w) kind = REQ_INSERT;
      else if (roll < ins_w + (100 - ins_w) * 6 / 10) kind = REQ_DELETE;
      else if ($urandom_range(0, 99) < 12) kind = REQ_SPARE;
      else kind = REQ_LOOKUP;
      if ($urandom_range(0, 99) < 70) v = pool[$urandom_range(0, 19)];
      else v = $urandom();
      add_item(kind, v);
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted < n_items) @(posedge clk);
    n = 0;
    while (exp_q.size() != 0 && n < 1000) begin
      @(posedge clk);
      n++;
    end
    repeat (10) @(posedge clk);
    if (exp_q.size() != 0) begin
      $error("%0d results never arrived", exp_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
